// ===== hdl/rmtm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmtm_pkg
// Shared constants, types and helpers for the red mask morphology block.
// ----------------------------------------------------------------------------
package rmtm_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned DIM_W  = COL_W + 1;               // width value, 1..MAX_WIDTH
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT) + 1;  // rows, incl. overrun while draining
  localparam int unsigned FILL_W = DIM_W + 1;               // up to 2*(W+1)
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned PIX_W  = 8;

  // Window stages: erode 3x3, dilate 3x3, dilate 5x5, erode 5x5
  localparam int unsigned NUM_STG = 4;
  localparam int unsigned STG_RAD [NUM_STG] = '{1, 1, 2, 2};
  localparam bit          STG_MAX [NUM_STG] = '{1'b0, 1'b1, 1'b1, 1'b0};

  typedef enum logic [1:0] {
    REG_RB_THR  = 2'd0,
    REG_BIN_THR = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } cfg_reg_e;

  // 0 reads as 1, values above the limit saturate
  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rmtm_if.sv =====
// ----------------------------------------------------------------------------
// rmtm interfaces
// Pixel, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmtm_pix_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rmtm_pkg::PIX_W-1:0]    blue;
  logic [rmtm_pkg::PIX_W-1:0]    red;

  modport source (output valid, kind, blue, red, input ready);
  modport sink   (input valid, kind, blue, red, output ready);
endinterface

interface rmtm_res_if;
  logic valid;
  logic ready;
  logic mask_bit;
  logic row_end;
  logic frame_end;

  modport source (output valid, mask_bit, row_end, frame_end, input ready);
  modport sink   (input valid, mask_bit, row_end, frame_end, output ready);
endinterface

interface rmtm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  index;
  logic [rmtm_pkg::CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rmtm_ram.sv =====
// ----------------------------------------------------------------------------
// rmtm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rmtm_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/red_mask_threshold_morphology.sv =====
// ----------------------------------------------------------------------------
// red_mask_threshold_morphology
// Red minus blue threshold mask, 3x3 opening then 5x5 closing, raster stream.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  pix_i   | in  | kind, blue, red
//  res_o   | out | mask_bit, row_end, frame_end
//  cfg_i   | in  | index, data (always ready)
//
//  One word per cycle sustained unless the output stalls; a word is registered
//  at the input, then all four window stages update together and a result
//  lands in the output register. Results lag the input by 6*W+6 counted words.
//  Line stores read one word ahead through a registered RAM port each.
//  Reset clears control only; line stores are never cleared, rows outside
//  the frame are masked. A stalled output holds the input register.
// ----------------------------------------------------------------------------
module red_mask_threshold_morphology (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmtm_pix_if.sink  pix_i,
  rmtm_res_if.source res_o,
  rmtm_cfg_if.sink  cfg_i
);

  localparam int unsigned NS    = rmtm_pkg::NUM_STG;
  localparam int unsigned COL_W = rmtm_pkg::COL_W;
  localparam int unsigned DIM_W = rmtm_pkg::DIM_W;
  localparam int unsigned ROW_W = rmtm_pkg::ROW_W;
  localparam int unsigned FIL_W = rmtm_pkg::FILL_W;
  localparam int unsigned CFG_W = rmtm_pkg::CFG_W;
  localparam int unsigned PIX_W = rmtm_pkg::PIX_W;

  // configuration
  logic [PIX_W-1:0] rb_thr_q, bin_thr_q;
  logic [CFG_W-1:0] width_q, height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_thr_q  <= '0;
      bin_thr_q <= '0;
      width_q   <= CFG_W'(640);
      height_q  <= CFG_W'(480);
    end else if (cfg_i.valid) begin
      unique case (rmtm_pkg::cfg_reg_e'(cfg_i.index))
        rmtm_pkg::REG_RB_THR:  rb_thr_q  <= cfg_i.data[PIX_W-1:0];
        rmtm_pkg::REG_BIN_THR: bin_thr_q <= cfg_i.data[PIX_W-1:0];
        rmtm_pkg::REG_WIDTH:   width_q   <= cfg_i.data;
        rmtm_pkg::REG_HEIGHT:  height_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  logic             pvalid_q, p_kind_q;
  logic [PIX_W-1:0] p_blue_q, p_red_q;
  logic             res_valid_q, res_mask_q, res_row_q, res_frame_q;
  logic             proc_go;

  assign proc_go     = pvalid_q && (!res_valid_q || res_o.ready);
  assign pix_i.ready = !pvalid_q || proc_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (pix_i.ready) begin
      pvalid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      p_kind_q <= pix_i.kind;
      p_blue_q <= pix_i.blue;
      p_red_q  <= pix_i.red;
    end
  end

  // frame control
  logic             active_q;
  logic [DIM_W-1:0] w_q, w_eff;
  logic [ROW_W-1:0] h_q, h_eff;
  logic             start, act, in_done, tick, tick_bit;
  logic             frame_last;

  logic             stg_vout [NS];
  logic             stg_bout [NS];
  logic [COL_W-1:0] stg_cx   [NS];
  logic [ROW_W-1:0] stg_cy   [NS];
  logic [ROW_W-1:0] in_row;

  assign start = proc_go && !active_q && !p_kind_q;
  assign act   = active_q || start;
  assign w_eff = start ? DIM_W'(rmtm_pkg::clamp_dim(width_q, CFG_W'(rmtm_pkg::MAX_WIDTH)))
                       : w_q;
  assign h_eff = start ? ROW_W'(rmtm_pkg::clamp_dim(height_q, CFG_W'(rmtm_pkg::MAX_HEIGHT)))
                       : h_q;

  // once all rows are in, every word (drain or pixel) only clocks the pipe
  assign in_done  = in_row >= h_eff;
  assign tick     = proc_go && act && (in_done || !p_kind_q);
  assign tick_bit = !in_done && !p_kind_q && (p_red_q > p_blue_q)
                    && ((p_red_q - p_blue_q) > rb_thr_q) && (bin_thr_q != 8'hFF);

  assign frame_last = stg_vout[NS-1]
                      && ({1'b0, stg_cx[NS-1]} == w_eff - DIM_W'(1))
                      && (stg_cy[NS-1] == h_eff - ROW_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (frame_last) begin
      active_q <= 1'b0;
    end else if (start) begin
      active_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      w_q <= w_eff;
      h_q <= h_eff;
    end
  end

  // window stages
  for (genvar s = 0; s < NS; s++) begin : g_stg
    localparam int unsigned R = rmtm_pkg::STG_RAD[s];
    localparam int unsigned M = 2 * R;
    localparam int unsigned N = 2 * R + 1;

    logic             vin, bin_w, vout, acc;
    logic [M-1:0]     rd_raw, rd_w, byp_data_q;
    logic             byp_q;
    logic [N-1:0]     tap   [N];
    logic [N-1:0]     tap_q [M];
    logic [N-1:0]     colv, rowv;
    logic [COL_W-1:0] ix_q, ix_eff, ix_nx, cx_q, cx_eff, cx_nx;
    logic [ROW_W-1:0] iy_q, iy_eff, iy_nx, cy_q, cy_eff, cy_nx;
    logic [FIL_W-1:0] f_q, f_eff, f_nx, tgt;
    logic             ix_wrap, cx_wrap;

    if (s == 0) begin : g_head
      assign vin   = tick;
      assign bin_w = tick_bit;
      assign in_row = iy_eff;
    end else begin : g_link
      assign vin   = stg_vout[s-1];
      assign bin_w = stg_bout[s-1];
    end

    assign ix_eff = start ? '0 : ix_q;
    assign iy_eff = start ? '0 : iy_q;
    assign cx_eff = start ? '0 : cx_q;
    assign cy_eff = start ? '0 : cy_q;
    assign f_eff  = start ? '0 : f_q;

    assign tgt  = (FIL_W'(w_eff) + FIL_W'(1)) * FIL_W'(R);
    assign vout = vin && (f_eff == tgt);

    assign ix_wrap = ({1'b0, ix_eff} == w_eff - DIM_W'(1));
    assign cx_wrap = ({1'b0, cx_eff} == w_eff - DIM_W'(1));

    always_comb begin
      ix_nx = ix_eff;
      iy_nx = iy_eff;
      cx_nx = cx_eff;
      cy_nx = cy_eff;
      f_nx  = f_eff;
      if (vin) begin
        ix_nx = ix_wrap ? '0 : ix_eff + COL_W'(1);
        iy_nx = ix_wrap ? iy_eff + ROW_W'(1) : iy_eff;
        if (f_eff != tgt) begin
          f_nx = f_eff + FIL_W'(1);
        end
      end
      if (vout) begin
        cx_nx = cx_wrap ? '0 : cx_eff + COL_W'(1);
        cy_nx = cx_wrap ? cy_eff + ROW_W'(1) : cy_eff;
      end
    end

    // line store: per column, the previous 2R rows, newest in bit 0
    rmtm_ram #(
      .WIDTH (M),
      .DEPTH (rmtm_pkg::MAX_WIDTH)
    ) u_lines (
      .clk_i   (clk_i),
      .we_i    (vin),
      .waddr_i (ix_eff),
      .wdata_i (tap[0][M-1:0]),
      .re_i    (vin || start),
      .raddr_i (ix_nx),
      .rdata_o (rd_raw)
    );

    // single-column frames read back the word just written
    assign rd_w = byp_q ? byp_data_q : rd_raw;

    always_ff @(posedge clk_i) begin
      if (vin || start) begin
        byp_q      <= vin && (ix_nx == ix_eff);
        byp_data_q <= tap[0][M-1:0];
      end
    end

    assign tap[0] = {rd_w, bin_w};
    for (genvar t = 1; t < N; t++) begin : g_tap
      assign tap[t] = tap_q[t-1];
    end

    always_ff @(posedge clk_i) begin
      if (vin) begin
        tap_q[0] <= tap[0];
        for (int t = 1; t < M; t++) begin
          tap_q[t] <= tap_q[t-1];
        end
      end
      if (vin || start) begin
        ix_q <= ix_nx;
        iy_q <= iy_nx;
        cx_q <= cx_nx;
        cy_q <= cy_nx;
        f_q  <= f_nx;
      end
    end

    // tap t is column cx+R-t, bit k is row cy+R-k
    for (genvar t = 0; t < N; t++) begin : g_colv
      if (t < R) begin : g_right
        assign colv[t] = ({1'b0, cx_eff} + DIM_W'(R - t)) < w_eff;
      end else if (t > R) begin : g_left
        assign colv[t] = cx_eff >= COL_W'(t - R);
      end else begin : g_mid
        assign colv[t] = 1'b1;
      end
    end

    for (genvar k = 0; k < N; k++) begin : g_rowv
      if (k <= R) begin : g_low
        assign rowv[k] = ({1'b0, cy_eff} + (ROW_W + 1)'(R - k)) < {1'b0, h_eff};
      end else begin : g_up
        assign rowv[k] = cy_eff >= ROW_W'(k - R);
      end
    end

    always_comb begin
      acc = !rmtm_pkg::STG_MAX[s];
      for (int t = 0; t < N; t++) begin
        for (int k = 0; k < N; k++) begin
          if (rmtm_pkg::STG_MAX[s]) begin
            acc = acc | (tap[t][k] & colv[t] & rowv[k]);
          end else begin
            acc = acc & (tap[t][k] | ~(colv[t] & rowv[k]));
          end
        end
      end
    end

    assign stg_vout[s] = vout;
    assign stg_bout[s] = acc;
    assign stg_cx[s]   = cx_eff;
    assign stg_cy[s]   = cy_eff;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc_go) begin
      res_valid_q <= stg_vout[NS-1];
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && stg_vout[NS-1]) begin
      res_mask_q  <= stg_bout[NS-1];
      res_row_q   <= ({1'b0, stg_cx[NS-1]} == w_eff - DIM_W'(1));
      res_frame_q <= frame_last;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.mask_bit  = res_mask_q;
  assign res_o.row_end   = res_row_q;
  assign res_o.frame_end = res_frame_q;

`ifndef SYNTHESIS
  a_frame_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_end |-> res_o.row_end)
    else $error("frame end word without row end");

  a_out_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vout[NS-1] |-> active_q)
    else $error("result produced outside an active frame");

  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last |=> !active_q)
    else $error("frame still active after its last word");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pvalid_q |-> pix_i.ready)
    else $error("input stalled with empty input register");
`endif

endmodule
